>>> hdl/token_bucket_window_rate_limiter_unit_macros.svh
// Assertion macros shared by the rate limiter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TOKEN_BUCKET_WINDOW_RATE_LIMITER_UNIT_MACROS_SVH
`define TOKEN_BUCKET_WINDOW_RATE_LIMITER_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define TBWRL_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error(MSG);

// Next-cycle implication, checked while out of reset.
`define TBWRL_ASSERT_NXT(LBL, CLK, RSTN, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

>>> hdl/tbwrl_pkg.sv
// Shared constants, codes and types of the rate limiter.
// Depends on nothing; used by tbwrl_div and the top level.
package tbwrl_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int CAP_W      = 16;
  localparam int LEVEL_W    = CAP_W + FRAC_BITS;
  localparam int REFILL_W   = 32;
  localparam int SUM_W      = REFILL_W + 1;
  localparam int NEED_W     = FRAC_BITS + 1;
  localparam int WTICKS_W   = 24;
  localparam int ELAPSED_W  = 32;
  localparam int REQ_W      = 16;
  localparam int COUNT_W    = 32;
  localparam int OUT_W      = 32;
  localparam int AMOUNT_W   = 16;
  localparam int KIND_W     = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_CNT_W  = $clog2(NEED_W);

  localparam logic [LEVEL_W-1:0] ONE_TOKEN = LEVEL_W'(1) << FRAC_BITS;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [REFILL_W-1:0] REFILL_RESET = REFILL_W'(1) << FRAC_BITS;
  localparam logic [WTICKS_W-1:0] WTICKS_RESET = WTICKS_W'(1000);
  localparam logic [REQ_W-1:0] MAXREQ_RESET = REQ_W'(100);

  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOW   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CONSUME = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESET   = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REFILL   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WTICKS   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MAXREQ   = 3'd4;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [LEVEL_W-1:0] cap_fixed(input logic [CAP_W-1:0] cap);
    cap_fixed = {cap, {FRAC_BITS{1'b0}}};
  endfunction

endpackage

>>> hdl/tbwrl_div.sv
// Restoring divider, one quotient bit per cycle, for the wait-time result.
// Depends on tbwrl_pkg and the assertion macro header.
`include "token_bucket_window_rate_limiter_unit_macros.svh"

module tbwrl_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [tbwrl_pkg::NEED_W-1:0]        dividend,
  input  logic [tbwrl_pkg::REFILL_W-1:0]      divisor,
  output logic [tbwrl_pkg::NEED_W-1:0]        quotient,
  output tbwrl_pkg::div_stat_t                stat
);

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [tbwrl_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [tbwrl_pkg::NEED_W-1:0]       dvd_r, dvd_nxt;
  logic [tbwrl_pkg::NEED_W-1:0]       quo_r, quo_nxt;
  logic [tbwrl_pkg::REFILL_W-1:0]     dvs_r, dvs_nxt;
  logic [tbwrl_pkg::REFILL_W-1:0]     rem_r, rem_nxt;
  logic [tbwrl_pkg::SUM_W-1:0]        trial;
  logic [tbwrl_pkg::SUM_W-1:0]        diff;

  assign trial = {rem_r, dvd_r[tbwrl_pkg::NEED_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = tbwrl_pkg::DIV_CNT_W'(tbwrl_pkg::NEED_W - 1);
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[tbwrl_pkg::NEED_W-2:0], 1'b0};
      if (!diff[tbwrl_pkg::SUM_W-1]) begin
        rem_nxt = diff[tbwrl_pkg::REFILL_W-1:0];
        quo_nxt = {quo_r[tbwrl_pkg::NEED_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[tbwrl_pkg::REFILL_W-1:0];
        quo_nxt = {quo_r[tbwrl_pkg::NEED_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  `TBWRL_ASSERT_NXT(a_div_start_busy, clk, rst_n, start, busy_r, "divider did not start")
  `TBWRL_ASSERT_NXT(a_div_last_step, clk, rst_n, busy_r && !start && cnt_r == '0, done_r && !busy_r, "divider did not finish after its last step")
  `TBWRL_ASSERT_IMP(a_div_done_idle, clk, rst_n, done_r, !busy_r, "divider done while busy")

endmodule

>>> hdl/token_bucket_window_rate_limiter_unit.sv
// Token bucket and fixed window rate limiter, top level with sequencer and state.
// Depends on tbwrl_pkg, tbwrl_div and the assertion macro header.
//
// Each input word (tick, allow, consume or reset) gives exactly one result word.
// An item that needs no wait computation passes the exec, wait check and done
// states before its result is written to the output register; the sequencer then
// returns to idle for the next word. In token mode with less than one token and a
// nonzero refill, the wait ticks come from a restoring divider that produces one
// quotient bit per cycle, 17 bits in all, in the divide state. The input is
// stalled until the sequencer is back in idle; a finished result waits in the
// output register while the next word is taken, and an item whose result is ready
// while the previous one is still held waits for it. Configuration writes must be
// made only while no item is in flight; the block itself does not enforce this.
`include "token_bucket_window_rate_limiter_unit_macros.svh"

module token_bucket_window_rate_limiter_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tbwrl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [tbwrl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [tbwrl_pkg::KIND_W-1:0]         in_kind,
  input  logic [tbwrl_pkg::AMOUNT_W-1:0]       in_amount,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_granted,
  output logic [tbwrl_pkg::OUT_W-1:0]          out_wait_ticks,
  output logic [tbwrl_pkg::OUT_W-1:0]          out_allowed_total,
  output logic [tbwrl_pkg::OUT_W-1:0]          out_rejected_total
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_WCHK = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                            state_r, state_nxt;
  logic                                  mode_r, mode_nxt;
  logic [tbwrl_pkg::CAP_W-1:0]           cap_r, cap_nxt;
  logic [tbwrl_pkg::REFILL_W-1:0]        refill_r, refill_nxt;
  logic [tbwrl_pkg::WTICKS_W-1:0]        wticks_r, wticks_nxt;
  logic [tbwrl_pkg::REQ_W-1:0]           maxreq_r, maxreq_nxt;
  logic [tbwrl_pkg::LEVEL_W-1:0]         level_r, level_nxt;
  logic [tbwrl_pkg::ELAPSED_W-1:0]       elapsed_r, elapsed_nxt;
  logic [tbwrl_pkg::REQ_W-1:0]           wcount_r, wcount_nxt;
  logic [tbwrl_pkg::COUNT_W-1:0]         gcount_r, gcount_nxt;
  logic [tbwrl_pkg::COUNT_W-1:0]         rcount_r, rcount_nxt;
  logic [tbwrl_pkg::KIND_W-1:0]          kind_r, kind_nxt;
  logic [tbwrl_pkg::AMOUNT_W-1:0]        amount_r, amount_nxt;
  logic                                  grant_r, grant_nxt;
  logic [tbwrl_pkg::OUT_W-1:0]           wait_r, wait_nxt;
  logic                                  oval_r, oval_nxt;
  logic                                  ogrant_r, ogrant_nxt;
  logic [tbwrl_pkg::OUT_W-1:0]           owait_r, owait_nxt;
  logic [tbwrl_pkg::OUT_W-1:0]           oallow_r, oallow_nxt;
  logic [tbwrl_pkg::OUT_W-1:0]           oreject_r, oreject_nxt;

  logic                                  div_start;
  logic [tbwrl_pkg::NEED_W-1:0]          div_dividend;
  logic [tbwrl_pkg::NEED_W-1:0]          div_quot;
  tbwrl_pkg::div_stat_t                  div_stat;

  logic                                  in_acc;
  logic                                  out_free;
  logic [tbwrl_pkg::LEVEL_W-1:0]         capf;
  logic [tbwrl_pkg::LEVEL_W-1:0]         capf_new;
  logic [tbwrl_pkg::SUM_W-1:0]           sum;
  logic [tbwrl_pkg::LEVEL_W-1:0]         need;
  logic                                  expired;
  logic [tbwrl_pkg::REQ_W-1:0]           wcount_eff;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !oval_r || !out_stall;
  assign capf     = tbwrl_pkg::cap_fixed(cap_r);
  assign capf_new = tbwrl_pkg::cap_fixed(cfg_wdata[tbwrl_pkg::CAP_W-1:0]);
  assign sum      = {1'b0, level_r} + {1'b0, refill_r};
  assign need     = {amount_r, {tbwrl_pkg::FRAC_BITS{1'b0}}};
  assign expired  = elapsed_r > {{(tbwrl_pkg::ELAPSED_W - tbwrl_pkg::WTICKS_W){1'b0}}, wticks_r};
  assign wcount_eff   = expired ? '0 : wcount_r;
  assign div_dividend = tbwrl_pkg::ONE_TOKEN[tbwrl_pkg::NEED_W-1:0]
                        - level_r[tbwrl_pkg::NEED_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    cap_nxt     = cap_r;
    refill_nxt  = refill_r;
    wticks_nxt  = wticks_r;
    maxreq_nxt  = maxreq_r;
    level_nxt   = level_r;
    elapsed_nxt = elapsed_r;
    wcount_nxt  = wcount_r;
    gcount_nxt  = gcount_r;
    rcount_nxt  = rcount_r;
    kind_nxt    = kind_r;
    amount_nxt  = amount_r;
    grant_nxt   = grant_r;
    wait_nxt    = wait_r;
    oval_nxt    = oval_r && out_stall;
    ogrant_nxt  = ogrant_r;
    owait_nxt   = owait_r;
    oallow_nxt  = oallow_r;
    oreject_nxt = oreject_r;
    div_start   = 1'b0;

    if (cfg_we) begin
      case (cfg_addr)
        tbwrl_pkg::REG_MODE: mode_nxt = cfg_wdata[0];
        tbwrl_pkg::REG_CAPACITY: begin
          cap_nxt = cfg_wdata[tbwrl_pkg::CAP_W-1:0];
          if (level_r > capf_new) begin
            level_nxt = capf_new;
          end
        end
        tbwrl_pkg::REG_REFILL: refill_nxt = cfg_wdata[tbwrl_pkg::REFILL_W-1:0];
        tbwrl_pkg::REG_WTICKS: wticks_nxt = cfg_wdata[tbwrl_pkg::WTICKS_W-1:0];
        tbwrl_pkg::REG_MAXREQ: maxreq_nxt = cfg_wdata[tbwrl_pkg::REQ_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          kind_nxt   = in_kind;
          amount_nxt = in_amount;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        grant_nxt = 1'b0;
        case (kind_r)
          tbwrl_pkg::KIND_TICK: begin
            if (!mode_r) begin
              level_nxt = (sum > {1'b0, capf}) ? capf : sum[tbwrl_pkg::LEVEL_W-1:0];
            end else if (elapsed_r != '1) begin
              elapsed_nxt = elapsed_r + 1'b1;
            end
          end
          tbwrl_pkg::KIND_ALLOW: begin
            if (!mode_r) begin
              if (level_r >= tbwrl_pkg::ONE_TOKEN) begin
                level_nxt = level_r - tbwrl_pkg::ONE_TOKEN;
                grant_nxt = 1'b1;
              end
            end else begin
              if (expired) begin
                elapsed_nxt = '0;
              end
              wcount_nxt = wcount_eff;
              if (wcount_eff < maxreq_r) begin
                wcount_nxt = wcount_eff + 1'b1;
                grant_nxt  = 1'b1;
              end
            end
            if (grant_nxt) begin
              gcount_nxt = gcount_r + 1'b1;
            end else begin
              rcount_nxt = rcount_r + 1'b1;
            end
          end
          tbwrl_pkg::KIND_CONSUME: begin
            if (!mode_r && level_r >= need) begin
              level_nxt = level_r - need;
              grant_nxt = 1'b1;
            end
          end
          default: begin
            if (!mode_r) begin
              level_nxt = capf;
            end else begin
              wcount_nxt  = '0;
              elapsed_nxt = '0;
            end
          end
        endcase
        state_nxt = ST_WCHK;
      end
      ST_WCHK: begin
        if (mode_r || level_r >= tbwrl_pkg::ONE_TOKEN) begin
          wait_nxt  = '0;
          state_nxt = ST_DONE;
        end else if (refill_r == '0) begin
          wait_nxt  = '1;
          state_nxt = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          wait_nxt  = tbwrl_pkg::OUT_W'(div_quot);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          oval_nxt    = 1'b1;
          ogrant_nxt  = grant_r;
          owait_nxt   = wait_r;
          oallow_nxt  = gcount_r[tbwrl_pkg::OUT_W-1:0];
          oreject_nxt = rcount_r[tbwrl_pkg::OUT_W-1:0];
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= 1'b0;
      cap_r     <= tbwrl_pkg::CAP_RESET;
      refill_r  <= tbwrl_pkg::REFILL_RESET;
      wticks_r  <= tbwrl_pkg::WTICKS_RESET;
      maxreq_r  <= tbwrl_pkg::MAXREQ_RESET;
      level_r   <= tbwrl_pkg::cap_fixed(tbwrl_pkg::CAP_RESET);
      elapsed_r <= '0;
      wcount_r  <= '0;
      gcount_r  <= '0;
      rcount_r  <= '0;
      oval_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      cap_r     <= cap_nxt;
      refill_r  <= refill_nxt;
      wticks_r  <= wticks_nxt;
      maxreq_r  <= maxreq_nxt;
      level_r   <= level_nxt;
      elapsed_r <= elapsed_nxt;
      wcount_r  <= wcount_nxt;
      gcount_r  <= gcount_nxt;
      rcount_r  <= rcount_nxt;
      oval_r    <= oval_nxt;
    end
    kind_r    <= kind_nxt;
    amount_r  <= amount_nxt;
    grant_r   <= grant_nxt;
    wait_r    <= wait_nxt;
    ogrant_r  <= ogrant_nxt;
    owait_r   <= owait_nxt;
    oallow_r  <= oallow_nxt;
    oreject_r <= oreject_nxt;
  end

  tbwrl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (refill_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = oval_r;
  assign out_granted        = ogrant_r;
  assign out_wait_ticks     = owait_r;
  assign out_allowed_total  = oallow_r;
  assign out_rejected_total = oreject_r;

  `TBWRL_ASSERT_IMP(a_level_capped, clk, rst_n, 1'b1, level_r <= capf, "level above capacity")
  `TBWRL_ASSERT_IMP(a_wait_token_mode, clk, rst_n, oval_r && owait_r != '0, !mode_r, "window wait")
  `TBWRL_ASSERT_NXT(a_accept_exec, clk, rst_n, in_acc, state_r == ST_EXEC, "word not executed")
  `TBWRL_ASSERT_IMP(a_div_only_in_div, clk, rst_n, div_stat.busy, state_r == ST_DIV, "stray divide")

endmodule
